### sv/obca_pkg.sv
// Shared types and constants for the bar count aggregator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package obca_pkg;

    // Configuration port geometry
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned GSIZE_W    = 16;
    localparam logic [GSIZE_W-1:0] GROUP_SIZE_RESET = 16'd5;

    // Register index codes (paddr[2])
    localparam logic REG_GROUP_SIZE = 1'b0;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // Field widths
    localparam int unsigned PRICE_W   = 32;
    localparam int unsigned IN_VOL_W  = 31;
    localparam int unsigned IN_AMT_W  = 40;
    localparam int unsigned OUT_VOL_W = 48;
    localparam int unsigned OUT_AMT_W = 56;
    localparam int unsigned TIME_W    = 32;

    // Input bar
    typedef struct packed {
        logic [PRICE_W-1:0]  in_open;
        logic [PRICE_W-1:0]  in_high;
        logic [PRICE_W-1:0]  in_low;
        logic [PRICE_W-1:0]  in_close;
        logic [IN_VOL_W-1:0] in_volume;
        logic [IN_AMT_W-1:0] in_amount;
        logic [TIME_W-1:0]   in_time;
        logic                series_end;
    } bar_in_t;

    // Merged bar
    typedef struct packed {
        logic [PRICE_W-1:0]   out_open;
        logic [PRICE_W-1:0]   out_high;
        logic [PRICE_W-1:0]   out_low;
        logic [PRICE_W-1:0]   out_close;
        logic [OUT_VOL_W-1:0] out_volume;
        logic [OUT_AMT_W-1:0] out_amount;
        logic [TIME_W-1:0]    out_time;
    } bar_out_t;

    // Classified bar as held in the queue
    typedef struct packed {
        bar_in_t bar;
        logic    first;   // opens a new group
        logic    emit;    // closes the group
    } q_entry_t;

    // Write side of the queue
    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

endpackage

`default_nettype wire

### sv/obca_front.sv
// Front end: accepts input bars, tracks the group count and tags each item.
// Depends on obca_pkg.
`default_nettype none

module obca_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [obca_pkg::GSIZE_W-1:0]    group_size,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire obca_pkg::bar_in_t               in_data,
    input  wire logic                            q_full,
    output obca_pkg::q_push_t                    q_wr
);

    logic [obca_pkg::GSIZE_W-1:0] bars_reg;
    logic [obca_pkg::GSIZE_W-1:0] bars_next;
    logic [obca_pkg::GSIZE_W:0]   count;
    logic                         accept;
    logic                         emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Classify: count including this bar against the group size
    assign count = {1'b0, bars_reg} + {{obca_pkg::GSIZE_W{1'b0}}, 1'b1};
    assign emit  = (count >= {1'b0, group_size}) || in_data.series_end;

    always_comb
    begin
        bars_next = bars_reg;
        if (accept)
        begin
            if (emit)
                bars_next = '0;
            else
                bars_next = count[obca_pkg::GSIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bars_reg <= '0;
        else
            bars_reg <= bars_next;
    end

    // Hand the tagged item to the queue
    always_comb
    begin
        q_wr.push        = accept;
        q_wr.entry.bar   = in_data;
        q_wr.entry.first = (bars_reg == '0);
        q_wr.entry.emit  = emit;
    end

endmodule

`default_nettype wire

### sv/obca_queue.sv
// Short queue of tagged bars between front and back.
// Depends on obca_pkg.
`default_nettype none

module obca_queue #(
    parameter int unsigned DEPTH = obca_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire obca_pkg::q_push_t    q_wr,
    output logic                      q_full,
    output logic                      q_valid,
    output obca_pkg::q_entry_t        q_head,
    input  wire logic                 q_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    obca_pkg::q_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_pop;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];
    assign do_pop  = q_pop && q_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_wr.push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (q_wr.push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !q_wr.push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            slot_reg[wr_ptr_reg] <= q_wr.entry;
    end

endmodule

`default_nettype wire

### sv/obca_back.sv
// Back end: merges queued bars into the running group and registers results.
// Depends on obca_pkg.
`default_nettype none

module obca_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire obca_pkg::q_entry_t   q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output obca_pkg::bar_out_t        out_data
);

    localparam int unsigned VW = obca_pkg::OUT_VOL_W;
    localparam int unsigned AW = obca_pkg::OUT_AMT_W;
    localparam int unsigned PW = obca_pkg::PRICE_W;

    logic [PW-1:0] open_reg, high_reg, low_reg;
    logic [VW-1:0] vol_reg;
    logic [AW-1:0] amt_reg;
    logic [PW-1:0] open_next, high_next, low_next;
    logic [VW-1:0] vol_next;
    logic [AW-1:0] amt_next;
    logic [VW:0]   vol_sum;
    logic [AW:0]   amt_sum;

    obca_pkg::bar_out_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;
    logic               load_out;

    // Pop whenever the item needs no output slot or one is free
    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && (!q_head.emit || slot_free);
    assign load_out  = q_pop && q_head.emit;

    // Merge the bar into the running group
    always_comb
    begin
        vol_sum = {1'b0, vol_reg}
                + {{(VW + 1 - obca_pkg::IN_VOL_W){1'b0}}, q_head.bar.in_volume};
        amt_sum = {1'b0, amt_reg}
                + {{(AW + 1 - obca_pkg::IN_AMT_W){1'b0}}, q_head.bar.in_amount};
        if (q_head.first)
        begin
            open_next = q_head.bar.in_open;
            high_next = q_head.bar.in_high;
            low_next  = q_head.bar.in_low;
            vol_next  = VW'(q_head.bar.in_volume);
            amt_next  = AW'(q_head.bar.in_amount);
        end
        else
        begin
            open_next = open_reg;
            high_next = (q_head.bar.in_high > high_reg) ? q_head.bar.in_high : high_reg;
            low_next  = (q_head.bar.in_low < low_reg) ? q_head.bar.in_low : low_reg;
            // Hold at full scale on carry out
            vol_next  = vol_sum[VW] ? {VW{1'b1}} : vol_sum[VW-1:0];
            amt_next  = amt_sum[AW] ? {AW{1'b1}} : amt_sum[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            open_reg <= open_next;
            high_reg <= high_next;
            low_reg  <= low_next;
            vol_reg  <= vol_next;
            amt_reg  <= amt_next;
        end
    end

    // Output register: load on a closing bar, drop valid when taken
    always_comb
    begin
        out_next            = out_reg;
        out_next.out_open   = open_next;
        out_next.out_high   = high_next;
        out_next.out_low    = low_next;
        out_next.out_close  = q_head.bar.in_close;
        out_next.out_volume = vol_next;
        out_next.out_amount = amt_next;
        out_next.out_time   = q_head.bar.in_time;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### sv/ohlc_bar_count_aggregator.sv
// Top level of the bar count aggregator: APB register, front, queue, back.
// Depends on obca_pkg, obca_front, obca_queue and obca_back.
//
//   channel   direction  handshake                 payload
//   in        in         in_valid / in_ready       in_data   (obca_pkg::bar_in_t)
//   out       out        out_valid / out_ready     out_data  (obca_pkg::bar_out_t)
//   config    in         psel, penable, pwrite     paddr, pwdata / prdata
//
// One bar is taken every cycle while the queue has room; a merged bar passes
// through the queue slot, then the output register in the back end.
// Reset clears the bar count, the queue and the output valid, and sets
// group_size to 5; no clearing pass is needed.
// An output stall holds the result register; bars that do not close a group
// keep draining, and in_ready drops once the queue of QUEUE_DEPTH items fills.
`default_nettype none

module ohlc_bar_count_aggregator #(
    parameter int unsigned QUEUE_DEPTH = obca_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input bars
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire obca_pkg::bar_in_t               in_data,
    // Merged bars
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output obca_pkg::bar_out_t                   out_data,
    // Configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [obca_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [obca_pkg::DATA_W-1:0]     pwdata,
    output logic [obca_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic [obca_pkg::GSIZE_W-1:0] gsize_reg, gsize_next;
    logic                         cfg_wr;
    obca_pkg::q_push_t            q_wr;
    obca_pkg::q_entry_t           q_head;
    logic                         q_full;
    logic                         q_valid;
    logic                         q_pop;

    // Register file: group_size only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        gsize_next = gsize_reg;
        if (cfg_wr && (paddr[2] == obca_pkg::REG_GROUP_SIZE))
            gsize_next = pwdata[obca_pkg::GSIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gsize_reg <= obca_pkg::GROUP_SIZE_RESET;
        else
            gsize_reg <= gsize_next;
    end

    always_comb
    begin
        if (paddr[2] == obca_pkg::REG_GROUP_SIZE)
            prdata = {{(obca_pkg::DATA_W - obca_pkg::GSIZE_W){1'b0}}, gsize_reg};
        else
            prdata = '0;
    end

    obca_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_size (gsize_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    obca_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    obca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
